### hdl/acrp_pkg.sv
package acrp_pkg;

  // One cache entry as it is kept in the slot memory.
  typedef struct packed {
    logic [15:0] addr;
    logic [31:0] data;
    logic        clean;
    logic [15:0] uses;
  } entry_t;

  // One result beat.
  typedef struct packed {
    logic        hit;
    logic [31:0] read_data;
    logic        evict_valid;
    logic [15:0] evict_addr;
    logic [31:0] evict_data;
    logic        evict_clean;
    logic        dup_put;
  } result_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_PUT   = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_UNDEF = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    POL_FIFO = 2'd0,
    POL_MRU  = 2'd1,
    POL_LRU  = 2'd2,
    POL_LFU  = 2'd3
  } policy_e;

  typedef enum logic {
    CFG_POLICY   = 1'b0,
    CFG_CAPACITY = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CK,
    ST_MISS,
    ST_EV_CK,
    ST_EV_LAST,
    ST_SHD,
    ST_SHD_WR,
    ST_INS,
    ST_MTF,
    ST_MTF_WR,
    ST_SIFT_DN,
    ST_SD_L,
    ST_SD_R,
    ST_SD_DEC,
    ST_SIFT_UP,
    ST_SU_CK,
    ST_DONE
  } state_e;

  localparam logic [15:0] USES_MAX = 16'hFFFF;
  localparam logic [15:0] USES_INIT = 16'd1;
  localparam logic [4:0]  CAPACITY_RESET = 5'd16;

endpackage

### hdl/acrp_ram.sv
module acrp_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/assoc_cache_replacement_policy_core.sv
// Steps: a search reads and checks one slot at a time, an eviction shift or a move to
// front reads and writes one slot at a time, sift down reads both children and decides
// at each heap level, and sift up reads and checks the parent at each level.
// One read and one write per cycle on the slot memory, with registered read.
// Throughput: one item at a time; a new item is taken while the last result waits.
// Reset: the cache is empty, policy is fifo and capacity is 16; no clearing pass.
module assoc_cache_replacement_policy_core #(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] addr_i,
  input  logic [31:0] data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [31:0] read_data_o,
  output logic        evict_valid_o,
  output logic [15:0] evict_addr_o,
  output logic [31:0] evict_data_o,
  output logic        evict_clean_o,
  output logic        dup_put_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [4:0]  cfg_wdata_i
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = $bits(acrp_pkg::entry_t);

  acrp_pkg::state_e  state_q, state_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     cidx_q, cidx_d;
  logic [CW-1:0]     used_q, used_d;
  acrp_pkg::entry_t  hold_q, hold_d;
  acrp_pkg::entry_t  child_q, child_d;
  logic              ins_pend_q, ins_pend_d;
  acrp_pkg::result_t res_q, res_d;
  acrp_pkg::result_t out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        kind_q, kind_d;
  logic [15:0]       addr_q, addr_d;
  logic [31:0]       data_q, data_d;
  logic [1:0]        policy_q;
  logic [4:0]        capacity_q;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  acrp_pkg::entry_t  ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata_raw;
  acrp_pkg::entry_t  rd;

  logic [CW-1:0]     cap_eff;
  logic [CW-1:0]     used_m1, idx_m1, idx_p1, qidx;
  logic [CW:0]       lidx, ridx;
  acrp_pkg::entry_t  hit_ent, new_ent;
  acrp_pkg::state_e  finish_st;

  acrp_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign rd = acrp_pkg::entry_t'(ram_rdata_raw);

  // Clamp the capacity register into 1..DEPTH.
  always_comb begin
    if (capacity_q == 5'd0) begin
      cap_eff = CW'(1);
    end else if (32'(capacity_q) > DEPTH) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(capacity_q);
    end
  end

  // Index arithmetic for shifts and heap moves.
  assign used_m1 = used_q - 1'b1;
  assign idx_m1  = idx_q - 1'b1;
  assign idx_p1  = idx_q + 1'b1;
  assign qidx    = idx_m1 >> 1;
  assign lidx    = {idx_q, 1'b1};
  assign ridx    = lidx + 1'b1;

  // Entry after a hit: new data on write, use count bumped for the heap.
  always_comb begin
    hit_ent = rd;
    if (kind_q == acrp_pkg::KIND_WRITE) begin
      hit_ent.data  = data_q;
      hit_ent.clean = 1'b0;
    end
    if (policy_q == acrp_pkg::POL_LFU && rd.uses != acrp_pkg::USES_MAX) begin
      hit_ent.uses = rd.uses + 1'b1;
    end
  end

  assign new_ent = '{addr: addr_q, data: data_q, clean: (kind_q == acrp_pkg::KIND_PUT),
                     uses: acrp_pkg::USES_INIT};

  // An eviction hands over to the insert when its reordering is done.
  assign finish_st = ins_pend_q ? acrp_pkg::ST_INS : acrp_pkg::ST_DONE;

  assign in_ready_o  = (state_q == acrp_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign hit_o         = out_q.hit;
  assign read_data_o   = out_q.read_data;
  assign evict_valid_o = out_q.evict_valid;
  assign evict_addr_o  = out_q.evict_addr;
  assign evict_data_o  = out_q.evict_data;
  assign evict_clean_o = out_q.evict_clean;
  assign dup_put_o     = out_q.dup_put;

  // Sequencer: next state, memory port and working registers.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cidx_d      = cidx_q;
    used_d      = used_q;
    hold_d      = hold_q;
    child_d     = child_q;
    ins_pend_d  = ins_pend_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    addr_d      = addr_q;
    data_d      = data_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = hold_q;
    ram_raddr   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      acrp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          kind_d     = kind_i;
          addr_d     = addr_i;
          data_d     = data_i;
          res_d      = '0;
          idx_d      = '0;
          ins_pend_d = 1'b0;
          if (kind_i != acrp_pkg::KIND_READ && kind_i != acrp_pkg::KIND_PUT &&
              kind_i != acrp_pkg::KIND_WRITE) begin
            state_d = acrp_pkg::ST_DONE;
          end else if (used_q == '0) begin
            state_d = acrp_pkg::ST_MISS;
          end else begin
            state_d = acrp_pkg::ST_SRCH_RD;
          end
        end
      end

      // Linear search: a read, then a check, for each slot.
      acrp_pkg::ST_SRCH_RD: begin
        ram_raddr = idx_q[AW-1:0];
        state_d   = acrp_pkg::ST_SRCH_CK;
      end

      acrp_pkg::ST_SRCH_CK: begin
        if (rd.addr == addr_q) begin
          res_d.hit = 1'b1;
          hold_d    = hit_ent;
          if (kind_q == acrp_pkg::KIND_READ) begin
            res_d.read_data = rd.data;
          end
          if (kind_q == acrp_pkg::KIND_PUT) begin
            res_d.dup_put = 1'b1;
            state_d       = acrp_pkg::ST_DONE;
          end else begin
            case (policy_q)
              acrp_pkg::POL_FIFO: begin
                ram_we    = (kind_q == acrp_pkg::KIND_WRITE);
                ram_waddr = idx_q[AW-1:0];
                ram_wdata = hit_ent;
                state_d   = acrp_pkg::ST_DONE;
              end
              acrp_pkg::POL_LFU: state_d = acrp_pkg::ST_SIFT_DN;
              default:           state_d = acrp_pkg::ST_MTF;
            endcase
          end
        end else if (idx_p1 == used_q) begin
          state_d = acrp_pkg::ST_MISS;
        end else begin
          idx_d   = idx_p1;
          state_d = acrp_pkg::ST_SRCH_RD;
        end
      end

      // Miss: report, or evict when full, then insert.
      acrp_pkg::ST_MISS: begin
        if (kind_q == acrp_pkg::KIND_READ) begin
          state_d = acrp_pkg::ST_DONE;
        end else if (used_q >= cap_eff && used_q != '0) begin
          ram_raddr = (policy_q == acrp_pkg::POL_LRU) ? used_m1[AW-1:0] : '0;
          state_d   = acrp_pkg::ST_EV_CK;
        end else begin
          state_d = acrp_pkg::ST_INS;
        end
      end

      acrp_pkg::ST_EV_CK: begin
        res_d.evict_valid = 1'b1;
        res_d.evict_addr  = rd.addr;
        res_d.evict_data  = rd.data;
        res_d.evict_clean = rd.clean;
        ins_pend_d        = 1'b1;
        case (policy_q)
          acrp_pkg::POL_LRU: begin
            used_d  = used_m1;
            state_d = acrp_pkg::ST_INS;
          end
          acrp_pkg::POL_LFU: begin
            ram_raddr = used_m1[AW-1:0];
            state_d   = acrp_pkg::ST_EV_LAST;
          end
          default: begin
            idx_d   = CW'(1);
            state_d = acrp_pkg::ST_SHD;
          end
        endcase
      end

      // Heap eviction: the last slot fills the root hole and sifts down.
      acrp_pkg::ST_EV_LAST: begin
        hold_d  = rd;
        used_d  = used_m1;
        idx_d   = '0;
        state_d = acrp_pkg::ST_SIFT_DN;
      end

      // Shift slots toward the front after evicting slot 0.
      acrp_pkg::ST_SHD: begin
        if (idx_q >= used_q) begin
          used_d  = used_m1;
          state_d = finish_st;
        end else begin
          ram_raddr = idx_q[AW-1:0];
          state_d   = acrp_pkg::ST_SHD_WR;
        end
      end

      acrp_pkg::ST_SHD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_m1[AW-1:0];
        ram_wdata = rd;
        idx_d     = idx_p1;
        state_d   = acrp_pkg::ST_SHD;
      end

      // Insert the new entry at the end, then place it by policy.
      acrp_pkg::ST_INS: begin
        hold_d     = new_ent;
        used_d     = used_q + 1'b1;
        idx_d      = used_q;
        ins_pend_d = 1'b0;
        case (policy_q)
          acrp_pkg::POL_FIFO: begin
            ram_we    = 1'b1;
            ram_waddr = used_q[AW-1:0];
            ram_wdata = new_ent;
            state_d   = acrp_pkg::ST_DONE;
          end
          acrp_pkg::POL_LFU: state_d = acrp_pkg::ST_SIFT_UP;
          default:           state_d = acrp_pkg::ST_MTF;
        endcase
      end

      // Move the held entry to the front, shifting the slots before it back.
      acrp_pkg::ST_MTF: begin
        if (idx_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          state_d   = finish_st;
        end else begin
          ram_raddr = idx_m1[AW-1:0];
          state_d   = acrp_pkg::ST_MTF_WR;
        end
      end

      acrp_pkg::ST_MTF_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = rd;
        idx_d     = idx_m1;
        state_d   = acrp_pkg::ST_MTF;
      end

      // Sift down with a hole: the held entry lands where it stops.
      acrp_pkg::ST_SIFT_DN: begin
        if (lidx >= {1'b0, used_q}) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q[AW-1:0];
          state_d   = finish_st;
        end else begin
          ram_raddr = lidx[AW-1:0];
          state_d   = acrp_pkg::ST_SD_L;
        end
      end

      acrp_pkg::ST_SD_L: begin
        child_d = rd;
        cidx_d  = lidx[CW-1:0];
        if (ridx < {1'b0, used_q}) begin
          ram_raddr = ridx[AW-1:0];
          state_d   = acrp_pkg::ST_SD_R;
        end else begin
          state_d = acrp_pkg::ST_SD_DEC;
        end
      end

      acrp_pkg::ST_SD_R: begin
        if (rd.uses < child_q.uses) begin
          child_d = rd;
          cidx_d  = ridx[CW-1:0];
        end
        state_d = acrp_pkg::ST_SD_DEC;
      end

      acrp_pkg::ST_SD_DEC: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        if (hold_q.uses < child_q.uses) begin
          state_d = finish_st;
        end else begin
          ram_wdata = child_q;
          idx_d     = cidx_q;
          state_d   = acrp_pkg::ST_SIFT_DN;
        end
      end

      // Sift up with a hole, moving larger parents down.
      acrp_pkg::ST_SIFT_UP: begin
        if (idx_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          state_d   = acrp_pkg::ST_DONE;
        end else begin
          ram_raddr = qidx[AW-1:0];
          state_d   = acrp_pkg::ST_SU_CK;
        end
      end

      acrp_pkg::ST_SU_CK: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        if (hold_q.uses < rd.uses) begin
          ram_wdata = rd;
          idx_d     = qidx;
          state_d   = acrp_pkg::ST_SIFT_UP;
        end else begin
          state_d = acrp_pkg::ST_DONE;
        end
      end

      // Hand the result to the output register once it is free.
      acrp_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = acrp_pkg::ST_IDLE;
        end
      end

      default: state_d = acrp_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= acrp_pkg::ST_IDLE;
      used_q      <= '0;
      ins_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
      policy_q    <= acrp_pkg::POL_FIFO;
      capacity_q  <= acrp_pkg::CAPACITY_RESET;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      ins_pend_q  <= ins_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == acrp_pkg::CFG_POLICY) begin
          policy_q <= cfg_wdata_i[1:0];
        end else begin
          capacity_q <= cfg_wdata_i;
        end
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    cidx_q  <= cidx_d;
    hold_q  <= hold_d;
    child_q <= child_d;
    res_q   <= res_d;
    out_q   <= out_d;
    kind_q  <= kind_d;
    addr_q  <= addr_d;
    data_q  <= data_d;
  end

endmodule

### test/assoc_cache_replacement_policy_core_chk.sv
`timescale 1ns / 1ps
// Watches both channels, keeps a shadow of the cache and compares each result beat.
module assoc_cache_replacement_policy_core_chk #(
  parameter int DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        kind_i,
  input  logic [15:0]       addr_i,
  input  logic [31:0]       data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  acrp_pkg::result_t res_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [4:0]        cfg_wdata_i,
  output int                fail_cnt_o,
  output int                pending_o,
  output int                hit_cnt_o,
  output int                evict_cnt_o
);

  acrp_pkg::entry_t  shadow [DEPTH];
  int                shadow_used;
  acrp_pkg::policy_e shadow_pol;
  logic [4:0]        shadow_cap;
  acrp_pkg::result_t expected_q [$];

  assign pending_o = expected_q.size();

  function automatic int find_addr(logic [15:0] a);
    for (int i = 0; i < shadow_used; i++)
      if (shadow[i].addr == a) return i;
    return -1;
  endfunction

  function automatic void swap_entries(int a, int b);
    acrp_pkg::entry_t t;
    t = shadow[a];
    shadow[a] = shadow[b];
    shadow[b] = t;
  endfunction

  // Heap sift-down that also swaps on equal use counts.
  function automatic void sift_down(int p);
    int l;
    int r;
    int c;
    forever begin
      l = 2 * p + 1;
      r = 2 * p + 2;
      if (l >= shadow_used) return;
      c = (r < shadow_used && shadow[r].uses < shadow[l].uses) ? r : l;
      if (shadow[p].uses < shadow[c].uses) return;
      swap_entries(p, c);
      p = c;
    end
  endfunction

  function automatic void sift_up(int p);
    int q;
    while (p > 0) begin
      q = (p - 1) / 2;
      if (!(shadow[p].uses < shadow[q].uses)) return;
      swap_entries(p, q);
      p = q;
    end
  endfunction

  function automatic void move_to_front(int i);
    acrp_pkg::entry_t t;
    t = shadow[i];
    for (; i > 0; i--) shadow[i] = shadow[i - 1];
    shadow[0] = t;
  endfunction

  function automatic void touch(int i);
    if (shadow_pol == acrp_pkg::POL_MRU || shadow_pol == acrp_pkg::POL_LRU) begin
      move_to_front(i);
    end else if (shadow_pol == acrp_pkg::POL_LFU) begin
      if (shadow[i].uses != acrp_pkg::USES_MAX) shadow[i].uses++;
      sift_down(i);
    end
  endfunction

  // Removes the policy victim and records it in the result.
  function automatic void evict_victim(ref acrp_pkg::result_t r);
    int v;
    v = (shadow_pol == acrp_pkg::POL_LRU) ? shadow_used - 1 : 0;
    r.evict_valid = 1'b1;
    r.evict_addr  = shadow[v].addr;
    r.evict_data  = shadow[v].data;
    r.evict_clean = shadow[v].clean;
    if (shadow_pol == acrp_pkg::POL_LFU) begin
      shadow[0] = shadow[shadow_used - 1];
      shadow_used--;
      sift_down(0);
    end else if (shadow_pol == acrp_pkg::POL_LRU) begin
      shadow_used--;
    end else begin
      for (int i = 1; i < shadow_used; i++) shadow[i - 1] = shadow[i];
      shadow_used--;
    end
  endfunction

  function automatic void insert_entry(logic [15:0] a, logic [31:0] d, logic cl,
                                       ref acrp_pkg::result_t r);
    int cap;
    int pos;
    cap = shadow_cap;
    if (cap < 1) cap = 1;
    if (cap > DEPTH) cap = DEPTH;
    if (shadow_used >= cap && shadow_used > 0) evict_victim(r);
    if (shadow_used >= DEPTH) return;
    pos = shadow_used;
    shadow_used++;
    shadow[pos] = '{addr: a, data: d, clean: cl, uses: acrp_pkg::USES_INIT};
    if (shadow_pol == acrp_pkg::POL_MRU || shadow_pol == acrp_pkg::POL_LRU) move_to_front(pos);
    else if (shadow_pol == acrp_pkg::POL_LFU) sift_up(pos);
  endfunction

  // Computes the result beat of one accepted request and updates the shadow.
  function automatic acrp_pkg::result_t cache_access(logic [1:0] k, logic [15:0] a,
                                                     logic [31:0] d);
    acrp_pkg::result_t r;
    int s;
    r = '0;
    if (k == acrp_pkg::KIND_UNDEF) return r;
    s = find_addr(a);
    if (k == acrp_pkg::KIND_READ) begin
      if (s >= 0) begin
        r.hit = 1'b1;
        r.read_data = shadow[s].data;
        touch(s);
      end
    end else if (k == acrp_pkg::KIND_PUT) begin
      if (s >= 0) begin
        r.hit = 1'b1;
        r.dup_put = 1'b1;
      end else begin
        insert_entry(a, d, 1'b1, r);
      end
    end else begin
      if (s >= 0) begin
        r.hit = 1'b1;
        touch(s);
        s = find_addr(a);
        shadow[s].data = d;
        shadow[s].clean = 1'b0;
      end else begin
        insert_entry(a, d, 1'b0, r);
      end
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_cnt_o++;
    end
  endtask

  // Sample both channels at each edge.
  always @(posedge clk_i or negedge rst_ni) begin
    acrp_pkg::result_t e;
    if (!rst_ni) begin
      shadow_used = 0;
      shadow_pol  = acrp_pkg::POL_FIFO;
      shadow_cap  = acrp_pkg::CAPACITY_RESET;
      expected_q.delete();
      fail_cnt_o  = 0;
      hit_cnt_o   = 0;
      evict_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == acrp_pkg::CFG_POLICY) begin
          shadow_pol = acrp_pkg::policy_e'(cfg_wdata_i[1:0]);
        end else begin
          shadow_cap = cfg_wdata_i;
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no request outstanding");
          fail_cnt_o++;
        end else begin
          e = expected_q.pop_front();
          compare_field("hit", e.hit, res_i.hit);
          compare_field("read_data", e.read_data, res_i.read_data);
          compare_field("evict_valid", e.evict_valid, res_i.evict_valid);
          compare_field("evict_addr", e.evict_addr, res_i.evict_addr);
          compare_field("evict_data", e.evict_data, res_i.evict_data);
          compare_field("evict_clean", e.evict_clean, res_i.evict_clean);
          compare_field("dup_put", e.dup_put, res_i.dup_put);
          if (e.hit) hit_cnt_o++;
          if (e.evict_valid) evict_cnt_o++;
        end
      end
      if (in_valid_i && in_ready_i)
        expected_q.push_back(cache_access(kind_i, addr_i, data_i));
    end
  end

endmodule

### test/assoc_cache_replacement_policy_core_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the replacement policy cache.
module assoc_cache_replacement_policy_core_tb;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        kind_i = '0;
  logic [15:0]       addr_i = '0;
  logic [31:0]       data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  acrp_pkg::result_t res;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = 1'b0;
  logic [4:0]        cfg_wdata_i = '0;
  int                fail_cnt;
  int                pending;
  int                hit_cnt;
  int                evict_cnt;
  logic [15:0]       addr_pool [8];
  bit                out_stall_en = 1'b1;
  logic [4:0]        caps [6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd6};

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  assoc_cache_replacement_policy_core DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .addr_i, .data_i,
    .out_valid_o, .out_ready_i,
    .hit_o(res.hit), .read_data_o(res.read_data), .evict_valid_o(res.evict_valid),
    .evict_addr_o(res.evict_addr), .evict_data_o(res.evict_data),
    .evict_clean_o(res.evict_clean), .dup_put_o(res.dup_put),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  assoc_cache_replacement_policy_core_chk CHK (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .addr_i, .data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .res_i(res), .cfg_we_i, .cfg_idx_i,
    .cfg_wdata_i, .fail_cnt_o(fail_cnt), .pending_o(pending), .hit_cnt_o(hit_cnt),
    .evict_cnt_o(evict_cnt)
  );

  // Receiver stalls: ready is held low for a random gap, then ready for one beat.
  always @(posedge clk_i) begin
    int gap;
    if (rst_ni) begin
      gap = out_stall_en ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Sends one request beat after a random gap; valid stays high into the next beat
  // when there is no gap.
  task automatic send_beat(logic [1:0] k, logic [15:0] a, logic [31:0] d, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    addr_i <= a;
    data_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drops valid and waits out every expected beat, then idles.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(acrp_pkg::cfg_idx_e idx, logic [4:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random phase; addresses mostly come from a small pool to get hits.
  task automatic random_phase(int n, bit burst);
    logic [15:0] a;
    logic [1:0]  k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) a = addr_pool[$urandom_range(0, 7)];
      else a = 16'($urandom);
      k = ($urandom_range(0, 19) == 0) ? acrp_pkg::KIND_UNDEF : 2'($urandom_range(0, 2));
      send_beat(k, a, $urandom, burst);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (addr_pool[i]) addr_pool[i] = 16'($urandom);
    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'hFFFF;

    // Directed: field extremes, duplicates, undefined kind, eviction at capacity 2.
    write_reg(acrp_pkg::CFG_CAPACITY, 5'd2);
    send_beat(acrp_pkg::KIND_READ, 16'h0000, 32'h0, 1'b0);
    send_beat(acrp_pkg::KIND_PUT, 16'h0000, 32'hFFFF_FFFF, 1'b0);
    send_beat(acrp_pkg::KIND_PUT, 16'h0000, 32'h1234_5678, 1'b0);
    send_beat(acrp_pkg::KIND_WRITE, 16'hFFFF, 32'h0000_0000, 1'b0);
    send_beat(acrp_pkg::KIND_READ, 16'h0000, 32'h0, 1'b0);
    send_beat(acrp_pkg::KIND_WRITE, 16'h0000, 32'hA5A5_5A5A, 1'b0);
    send_beat(acrp_pkg::KIND_UNDEF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_beat(acrp_pkg::KIND_PUT, 16'h5555, 32'h5555_5555, 1'b0);
    send_beat(acrp_pkg::KIND_WRITE, 16'hAAAA, 32'hAAAA_AAAA, 1'b0);
    send_beat(acrp_pkg::KIND_READ, 16'hAAAA, 32'h0, 1'b0);
    // Sender holds off until the cache has answered everything.
    drain();

    // Each policy with several capacities, extremes and out-of-range values included.
    for (int p = 0; p < 4; p++) begin
      for (int c = 0; c < 6; c++) begin
        write_reg(acrp_pkg::CFG_POLICY, 5'(p));
        write_reg(acrp_pkg::CFG_CAPACITY, caps[(c + p) % 6]);
        out_stall_en = (c != 2);
        random_phase(36, c == 2);
        drain();
      end
      // Lower capacity under a full cache, then switch policy mid-use.
      write_reg(acrp_pkg::CFG_CAPACITY, 5'd2);
      random_phase(12, 1'b0);
      drain();
      write_reg(acrp_pkg::CFG_POLICY, 5'((p + 1) % 4));
      random_phase(12, 1'b0);
      drain();
    end

    $display("Ran about 970 requests over all four policies and capacities 0 to 31;");
    $display("%0d hits and %0d evictions were checked.", hit_cnt, evict_cnt);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
